FILE: rtl/two_key_lookup_table_defines.svh
// Assertion macros used by the checker of the lookup table.
`ifndef TWO_KEY_LOOKUP_TABLE_DEFINES_SVH
`define TWO_KEY_LOOKUP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TKL_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TKL_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tkl_pkg.sv
package tkl_pkg;

	localparam int OP_BITS     = 2;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT   = 2'd0,
		OP_FIND_K1  = 2'd1,
		OP_FIND_K2  = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_DONE = 2'd0,
		STAT_DUP  = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic use_first;
		logic use_second;
	} match_ctl_t;

	function automatic match_ctl_t match_ctl(input op_t op);
		match_ctl_t c;
		case (op)
			OP_INSERT: begin
				c.use_first  = 1'b1;
				c.use_second = 1'b1;
			end
			OP_FIND_K1: begin
				c.use_first  = 1'b1;
				c.use_second = 1'b0;
			end
			OP_FIND_K2: begin
				c.use_first  = 1'b0;
				c.use_second = 1'b1;
			end
			default: begin
				c.use_first  = 1'b0;
				c.use_second = 1'b0;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/tkl_store.sv
module tkl_store import tkl_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 72
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/tkl_match.sv
module tkl_match import tkl_pkg::*; #(
	parameter int FIRST_KEY_BITS  = 32,
	parameter int SECOND_KEY_BITS = 8
) (
	input  match_ctl_t                 ctl,
	input  logic [FIRST_KEY_BITS-1:0]  first_key,
	input  logic [SECOND_KEY_BITS-1:0] second_key,
	input  logic [FIRST_KEY_BITS-1:0]  entry_first_key,
	input  logic [SECOND_KEY_BITS-1:0] entry_second_key,
	output logic                       hit
);

	logic eq_first;
	logic eq_second;

	assign eq_first  = (first_key == entry_first_key);
	assign eq_second = (second_key == entry_second_key);
	assign hit = (ctl.use_first | ctl.use_second)
		& (eq_first | ~ctl.use_first)
		& (eq_second | ~ctl.use_second);

endmodule

FILE: rtl/two_key_lookup_table.sv
// Channel  Dir  tvalid/tready        tdata / tuser (lowest bit up)
// s        in   s_tvalid, s_tready   tdata: first_key, second_key, entry_value; tuser: operation
// m        out  m_tvalid, m_tready   tdata: found, value_out, status, entry_count
//
// While a request is scanned, one shared key comparator
// walks the stored entries in slot order through a registered memory read port,
// then the finish state writes the entry or loads the result. A find or a duplicate
// insert stops at its first hit; clear skips the scan. s_tready is high only while idle.
// A finished result waits in the output register while the next request is accepted;
// the finish state holds while that register is full and stalled. arst_n empties the table.
module two_key_lookup_table import tkl_pkg::*; #(
	parameter int CAPACITY        = 16,
	parameter int FIRST_KEY_BITS  = 32,
	parameter int SECOND_KEY_BITS = 8,
	parameter int VALUE_BITS      = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// first_key, second_key, entry_value
	input  logic [((FIRST_KEY_BITS+SECOND_KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// operation
	input  logic [OP_BITS-1:0]                     s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// found, value_out, status, entry_count
	output logic [((VALUE_BITS+STATUS_BITS+COUNT_BITS+1+7)/8)*8-1:0] m_tdata
);

	localparam int ENTRY_W = FIRST_KEY_BITS + SECOND_KEY_BITS + VALUE_BITS;
	localparam int OUT_W   = ((VALUE_BITS + STATUS_BITS + COUNT_BITS + 1 + 7) / 8) * 8;
	localparam int AW      = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                      state_q;
	op_t                         op_q;
	logic [FIRST_KEY_BITS-1:0]   k1_q;
	logic [SECOND_KEY_BITS-1:0]  k2_q;
	logic [VALUE_BITS-1:0]       val_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            idx_q;
	logic                        pend_q;
	logic                        hit_q;
	logic [VALUE_BITS-1:0]       hit_val_q;
	logic                        m_valid_q;
	logic                        found_q;
	logic [VALUE_BITS-1:0]       value_out_q;
	status_t                     status_q;
	logic [COUNT_BITS-1:0]       entry_count_q;

	logic                        accept;
	logic                        more;
	logic                        cmp_hit;
	logic                        hit_now;
	logic                        out_free;
	logic                        is_full;
	logic                        wr_en;
	logic                        rd_en;
	logic [ENTRY_W-1:0]          rd_data;
	logic [FIRST_KEY_BITS-1:0]   rd_k1;
	logic [SECOND_KEY_BITS-1:0]  rd_k2;
	logic [VALUE_BITS-1:0]       rd_val;
	status_t                     status_d;
	logic [CNT_W-1:0]            count_d;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign more     = (idx_q < count_q);
	assign hit_now  = pend_q & cmp_hit;
	assign out_free = ~m_valid_q | m_tready;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign rd_en    = (state_q == S_SCAN) & ~hit_now & more;

	assign rd_k1  = rd_data[FIRST_KEY_BITS-1:0];
	assign rd_k2  = rd_data[FIRST_KEY_BITS+SECOND_KEY_BITS-1:FIRST_KEY_BITS];
	assign rd_val = rd_data[ENTRY_W-1:FIRST_KEY_BITS+SECOND_KEY_BITS];

	always_comb begin
		status_d = STAT_DONE;
		count_d  = count_q;
		wr_en    = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (hit_q) begin
					status_d = STAT_DUP;
				end else if (is_full) begin
					status_d = STAT_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					wr_en   = (state_q == S_FINISH) & out_free;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	tkl_store #(
		.DEPTH (CAPACITY),
		.WIDTH (ENTRY_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({val_q, k2_q, k1_q}),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	tkl_match #(
		.FIRST_KEY_BITS  (FIRST_KEY_BITS),
		.SECOND_KEY_BITS (SECOND_KEY_BITS)
	) u_match (
		.ctl              (match_ctl(op_q)),
		.first_key        (k1_q),
		.second_key       (k2_q),
		.entry_first_key  (rd_k1),
		.entry_second_key (rd_k2),
		.hit              (cmp_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_INSERT;
			k1_q          <= '0;
			k2_q          <= '0;
			val_q         <= '0;
			count_q       <= '0;
			idx_q         <= '0;
			pend_q        <= 1'b0;
			hit_q         <= 1'b0;
			hit_val_q     <= '0;
			m_valid_q     <= 1'b0;
			found_q       <= 1'b0;
			value_out_q   <= '0;
			status_q      <= STAT_DONE;
			entry_count_q <= '0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_FINISH) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= op_t'(s_tuser);
						k1_q   <= s_tdata[FIRST_KEY_BITS-1:0];
						k2_q   <= s_tdata[FIRST_KEY_BITS+SECOND_KEY_BITS-1:FIRST_KEY_BITS];
						val_q  <= s_tdata[ENTRY_W-1:FIRST_KEY_BITS+SECOND_KEY_BITS];
						idx_q  <= '0;
						pend_q <= 1'b0;
						hit_q  <= 1'b0;
						state_q <= (op_t'(s_tuser) == OP_CLEAR) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit_now) begin
						hit_q     <= 1'b1;
						hit_val_q <= rd_val;
						pend_q    <= 1'b0;
						state_q   <= S_FINISH;
					end else if (more) begin
						idx_q  <= idx_q + CNT_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						m_valid_q     <= 1'b1;
						found_q       <= hit_q & (op_q == OP_FIND_K1 || op_q == OP_FIND_K2);
						value_out_q   <= (hit_q && (op_q == OP_FIND_K1 || op_q == OP_FIND_K2))
							? hit_val_q : '0;
						status_q      <= status_d;
						entry_count_q <= COUNT_BITS'(count_d);
						count_q       <= count_d;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({entry_count_q, status_q, value_out_q, found_q});

endmodule

FILE: rtl/tkl_checker.sv
`include "two_key_lookup_table_defines.svh"

module tkl_checker import tkl_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input logic                                                   clk,
	input logic                                                   arst_n,
	input logic                                                   s_tvalid,
	input logic                                                   s_tready,
	input logic                                                   m_tvalid,
	input logic                                                   m_tready,
	input logic [((VALUE_BITS+STATUS_BITS+COUNT_BITS+1+7)/8)*8-1:0] m_tdata
);

	`TKL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`TKL_ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready right after a request")
	`TKL_ASSERT_NOW(a_found_done, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[VALUE_BITS+STATUS_BITS:VALUE_BITS+1] == STAT_DONE, "found with non-done status")
	`TKL_ASSERT_NOW(a_miss_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[VALUE_BITS:1] == '0, "value nonzero without a match")

endmodule

bind two_key_lookup_table tkl_checker #(.VALUE_BITS(VALUE_BITS)) u_tkl_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tkl_pkg::*;

	localparam int SLOTS     = 16;
	localparam int RUN_LIMIT = 400000;
	localparam int TAIL      = 40;

	typedef struct packed {
		op_t         op;
		logic [31:0] first_key;
		logic [7:0]  second_key;
		logic [31:0] entry_value;
	} lookup_req_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0]  entry_count;
		logic [STATUS_BITS-1:0] status;
		logic [31:0]            value_out;
		logic                   found;
	} lookup_reply_t;

	typedef struct {
		lookup_req_t   req;
		bit            typed;
		lookup_reply_t reply;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	two_key_lookup_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	bit            slot_used [SLOTS];
	logic [31:0]   first_keys [SLOTS];
	logic [7:0]    second_keys [SLOTS];
	logic [31:0]   slot_values [SLOTS];
	int            entries_held;

	lookup_reply_t replies_due [$];
	dir_row_t      dir_rows [$];
	int            mismatches;
	int            requests_taken;
	int            stall_pct;
	int            cycles;

	logic [31:0] k1_pool [0:5] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
		32'hDEAD_BEEF, 32'h0000_FFFF};
	logic [7:0]  k2_pool [0:4] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5A};

	function automatic lookup_reply_t table_op_reply(input lookup_req_t rq);
		lookup_reply_t rp;
		bit            dup;
		bit            hit;
		rp = '0;
		rp.status = STAT_DONE;
		case (rq.op)
			OP_INSERT: begin
				dup = 1'b0;
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i] && first_keys[i] == rq.first_key &&
							second_keys[i] == rq.second_key)
						dup = 1'b1;
				if (dup) begin
					rp.status = STAT_DUP;
				end else if (entries_held >= SLOTS) begin
					rp.status = STAT_FULL;
				end else begin
					slot_used[entries_held]   = 1'b1;
					first_keys[entries_held]  = rq.first_key;
					second_keys[entries_held] = rq.second_key;
					slot_values[entries_held] = rq.entry_value;
					entries_held++;
				end
			end
			OP_FIND_K1, OP_FIND_K2: begin
				for (int i = 0; i < SLOTS; i++) begin
					hit = slot_used[i] && ((rq.op == OP_FIND_K1) ?
						(first_keys[i] == rq.first_key) : (second_keys[i] == rq.second_key));
					if (hit && !rp.found) begin
						rp.found     = 1'b1;
						rp.value_out = slot_values[i];
					end
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					slot_used[i] = 1'b0;
				entries_held = 0;
			end
		endcase
		rp.entry_count = entries_held[COUNT_BITS-1:0];
		return rp;
	endfunction

	function automatic lookup_req_t random_request();
		lookup_req_t rq;
		int          pick;
		pick = $urandom_range(0, 999);
		if (pick < 25)
			rq.op = OP_CLEAR;
		else if (pick < 525)
			rq.op = OP_INSERT;
		else if (pick < 765)
			rq.op = OP_FIND_K1;
		else
			rq.op = OP_FIND_K2;
		rq.first_key   = ($urandom_range(0, 9) < 7) ? k1_pool[$urandom_range(0, 5)] : $urandom;
		rq.second_key  = ($urandom_range(0, 9) < 7) ? k2_pool[$urandom_range(0, 4)]
			: 8'($urandom);
		rq.entry_value = $urandom;
		return rq;
	endfunction

	function automatic void add_row(input op_t op, input logic [31:0] k1, input logic [7:0] k2,
			input logic [31:0] v, input bit typed, input logic fnd, input logic [31:0] vout,
			input status_t st, input int cnt);
		dir_row_t row;
		row.req.op             = op;
		row.req.first_key      = k1;
		row.req.second_key     = k2;
		row.req.entry_value    = v;
		row.typed              = typed;
		row.reply.found        = fnd;
		row.reply.value_out    = vout;
		row.reply.status       = st;
		row.reply.entry_count  = cnt[COUNT_BITS-1:0];
		dir_rows.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_request(input lookup_req_t rq, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rq.entry_value, rq.second_key, rq.first_key};
		s_tuser  <= rq.op;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		lookup_reply_t got;
		lookup_reply_t want;
		lookup_req_t   rq;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (replies_due.size() == 0) begin
					flag_mismatch("result with no request pending", m_tdata[31:0], '0);
				end else begin
					want = replies_due.pop_front();
					if (got.found !== want.found)
						flag_mismatch("found", 32'(got.found), 32'(want.found));
					if (got.value_out !== want.value_out)
						flag_mismatch("value_out", got.value_out, want.value_out);
					if (got.status !== want.status)
						flag_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.entry_count !== want.entry_count)
						flag_mismatch("entry_count", 32'(got.entry_count),
							32'(want.entry_count));
				end
			end
			if (s_tvalid && s_tready) begin
				rq.op          = op_t'(s_tuser);
				rq.first_key   = s_tdata[31:0];
				rq.second_key  = s_tdata[39:32];
				rq.entry_value = s_tdata[71:40];
				want = table_op_reply(rq);
				if (requests_taken < dir_rows.size() && dir_rows[requests_taken].typed)
					want = dir_rows[requests_taken].reply;
				replies_due.push_back(want);
				requests_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("FAIL two_key_lookup_table");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		int idle_by_phase [4];
		int stall_by_phase [4];
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = OP_INSERT;
		mismatches     = 0;
		requests_taken = 0;
		stall_pct      = 0;
		cycles         = 0;
		entries_held   = 0;
		idle_by_phase  = '{0, 61, 0, 19};
		stall_by_phase = '{0, 0, 61, 19};
		for (int i = 0; i < SLOTS; i++)
			slot_used[i] = 1'b0;

		add_row(OP_FIND_K1, 32'h0, 8'h00, 32'h0, 1, 1'b0, 32'h0, STAT_DONE, 0);
		add_row(OP_FIND_K2, 32'h0, 8'hFF, 32'h0, 1, 1'b0, 32'h0, STAT_DONE, 0);
		add_row(OP_CLEAR, 32'h0, 8'h00, 32'h0, 1, 1'b0, 32'h0, STAT_DONE, 0);
		add_row(OP_INSERT, 32'h0, 8'h00, 32'h0, 1, 1'b0, 32'h0, STAT_DONE, 1);
		add_row(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1, 1'b0, 32'h0, STAT_DONE, 2);
		add_row(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'h1234_5678, 1, 1'b0, 32'h0, STAT_DUP, 2);
		add_row(OP_FIND_K1, 32'hFFFF_FFFF, 8'h00, 32'h0, 1, 1'b1, 32'hFFFF_FFFF,
			STAT_DONE, 2);
		add_row(OP_FIND_K2, 32'hFFFF_FFFF, 8'h00, 32'h0, 1, 1'b1, 32'h0, STAT_DONE, 2);
		add_row(OP_INSERT, 32'h0, 8'hFF, 32'h5A5A_C3C3, 0, 1'b0, 32'h0, STAT_DONE, 0);
		add_row(OP_FIND_K2, 32'h0, 8'hFF, 32'h0, 0, 1'b0, 32'h0, STAT_DONE, 0);
		for (int i = 1; i <= 13; i++)
			add_row(OP_INSERT, 32'h1 << (2 * i), i[7:0], $urandom, 0, 1'b0, 32'h0,
				STAT_DONE, 0);
		add_row(OP_INSERT, 32'h1234_5678, 8'h77, 32'hAAAA_5555, 1, 1'b0, 32'h0,
			STAT_FULL, SLOTS);
		add_row(OP_INSERT, 32'h0, 8'h00, 32'h1, 1, 1'b0, 32'h0, STAT_DUP, SLOTS);
		add_row(OP_FIND_K1, 32'h0, 8'h00, 32'h0, 0, 1'b0, 32'h0, STAT_DONE, 0);
		add_row(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1, 1'b0, 32'h0, STAT_DONE, 0);

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, 0);
		drain_replies();

		for (int ph = 0; ph < 4; ph++) begin
			stall_pct = stall_by_phase[ph];
			for (int n = 0; n < 288; n++)
				send_request(random_request(), idle_by_phase[ph]);
			drain_replies();
		end

		stall_pct = 0;
		repeat (TAIL) @(negedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("PASS two_key_lookup_table");
		else
			$display("FAIL two_key_lookup_table");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tkl_pkg.sv
rtl/tkl_store.sv
rtl/tkl_match.sv
rtl/two_key_lookup_table.sv
rtl/tkl_checker.sv
dv/tb_top.sv
